[design/jdce_pkg.sv]
// Shared types, constants and codes of the joystick direction command encoder.
package jdce_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int CFG_W       = 12;
   localparam int CMP_W       = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;
   localparam int SCALE       = 100;
   localparam int SCALE_W     = 7;
   localparam int Q_W         = 7;
   localparam int NUM_W       = CFG_W + SCALE_W;
   localparam int CNT_W       = 3;
   localparam int NORM_W      = 8;
   localparam int DIFF_W      = 9;
   localparam int SQ_W        = 15;
   localparam int ADDR_W      = 5;
   localparam int DATA_W      = 32;
   localparam int IDX_W       = ADDR_W - 2;

   // register indexes
   localparam logic [IDX_W-1:0] REG_CENTER_X    = 3'd0;
   localparam logic [IDX_W-1:0] REG_FULL_X      = 3'd1;
   localparam logic [IDX_W-1:0] REG_CENTER_Y    = 3'd2;
   localparam logic [IDX_W-1:0] REG_FULL_Y      = 3'd3;
   localparam logic [IDX_W-1:0] REG_DEAD_ZONE   = 3'd4;
   localparam logic [IDX_W-1:0] REG_CHANGE_STEP = 3'd5;
   localparam logic [IDX_W-1:0] REG_FAST_LEVEL  = 3'd6;

   // register reset values
   localparam logic [CFG_W-1:0] RST_CENTER_X    = 12'd1800;
   localparam logic [CFG_W-1:0] RST_FULL_X      = 12'd4000;
   localparam logic [CFG_W-1:0] RST_CENTER_Y    = 12'd1900;
   localparam logic [CFG_W-1:0] RST_FULL_Y      = 12'd4050;
   localparam logic [6:0]       RST_DEAD_ZONE   = 7'd30;
   localparam logic [7:0]       RST_CHANGE_STEP = 8'd30;
   localparam logic [6:0]       RST_FAST_LEVEL  = 7'd70;

   // message kinds
   localparam logic [1:0] MSG_STOP = 2'd0;
   localparam logic [1:0] MSG_MOVE = 2'd1;
   localparam logic [1:0] MSG_KEY  = 2'd2;

   // directions
   localparam logic [3:0] DIR_STOP = 4'd0;
   localparam logic [3:0] DIR_F    = 4'd1;
   localparam logic [3:0] DIR_B    = 4'd2;
   localparam logic [3:0] DIR_L    = 4'd3;
   localparam logic [3:0] DIR_R    = 4'd4;
   localparam logic [3:0] DIR_FR   = 4'd5;
   localparam logic [3:0] DIR_FL   = 4'd6;
   localparam logic [3:0] DIR_BR   = 4'd7;
   localparam logic [3:0] DIR_BL   = 4'd8;
   localparam logic [3:0] DIR_NONE = 4'd15;

   // speeds
   localparam logic [1:0] SPD_STOP = 2'd0;
   localparam logic [1:0] SPD_SLOW = 2'd1;
   localparam logic [1:0] SPD_FAST = 2'd2;
   localparam logic [1:0] SPD_NONE = 2'd3;

   // button codes
   localparam logic [3:0] BTN_FIRST = 4'd1;
   localparam logic [3:0] BTN_LAST  = 4'd11;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] adc_x;
      logic [SAMPLE_BITS-1:0] adc_y;
      logic [3:0]             button;
   } req_type;

   typedef struct packed {
      logic [1:0] msg_kind;
      logic [3:0] direction;
      logic [1:0] speed;
      logic [3:0] key_code;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [CFG_W-1:0] center_x;
      logic [CFG_W-1:0] full_x;
      logic [CFG_W-1:0] center_y;
      logic [CFG_W-1:0] full_y;
      logic [6:0]       dead_zone;
      logic [7:0]       change_step;
      logic [6:0]       fast_level;
   } cfg_type;

   typedef struct packed {
      logic load_item;
      logic setup;
      logic axis_y;
      logic div_step;
      logic store;
      logic eval;
      logic load_joy;
      logic load_key;
   } cmd_type;

   typedef struct packed {
      logic skip_div;
      logic div_last;
      logic has_joy;
      logic has_key;
      logic out_free;
   } sts_type;

endpackage

[design/jdce_csr.sv]
// Configuration register file with APB-style access.
module jdce_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [jdce_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [jdce_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [jdce_pkg::DATA_W-1:0]  csr_prdata,
   output logic                         csr_pready,
   output jdce_pkg::cfg_type            cfg
);

   jdce_pkg::cfg_type              cfg_ff, cfg_in;
   logic [jdce_pkg::IDX_W-1:0]     idx;
   logic                           wr;

   assign idx        = csr_paddr[jdce_pkg::ADDR_W-1:2];
   assign wr         = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            jdce_pkg::REG_CENTER_X:    cfg_in.center_x    = csr_pwdata[jdce_pkg::CFG_W-1:0];
            jdce_pkg::REG_FULL_X:      cfg_in.full_x      = csr_pwdata[jdce_pkg::CFG_W-1:0];
            jdce_pkg::REG_CENTER_Y:    cfg_in.center_y    = csr_pwdata[jdce_pkg::CFG_W-1:0];
            jdce_pkg::REG_FULL_Y:      cfg_in.full_y      = csr_pwdata[jdce_pkg::CFG_W-1:0];
            jdce_pkg::REG_DEAD_ZONE:   cfg_in.dead_zone   = csr_pwdata[6:0];
            jdce_pkg::REG_CHANGE_STEP: cfg_in.change_step = csr_pwdata[7:0];
            jdce_pkg::REG_FAST_LEVEL:  cfg_in.fast_level  = csr_pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         jdce_pkg::REG_CENTER_X:    csr_prdata = jdce_pkg::DATA_W'(cfg_ff.center_x);
         jdce_pkg::REG_FULL_X:      csr_prdata = jdce_pkg::DATA_W'(cfg_ff.full_x);
         jdce_pkg::REG_CENTER_Y:    csr_prdata = jdce_pkg::DATA_W'(cfg_ff.center_y);
         jdce_pkg::REG_FULL_Y:      csr_prdata = jdce_pkg::DATA_W'(cfg_ff.full_y);
         jdce_pkg::REG_DEAD_ZONE:   csr_prdata = jdce_pkg::DATA_W'(cfg_ff.dead_zone);
         jdce_pkg::REG_CHANGE_STEP: csr_prdata = jdce_pkg::DATA_W'(cfg_ff.change_step);
         jdce_pkg::REG_FAST_LEVEL:  csr_prdata = jdce_pkg::DATA_W'(cfg_ff.fast_level);
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_x    <= jdce_pkg::RST_CENTER_X;
         cfg_ff.full_x      <= jdce_pkg::RST_FULL_X;
         cfg_ff.center_y    <= jdce_pkg::RST_CENTER_Y;
         cfg_ff.full_y      <= jdce_pkg::RST_FULL_Y;
         cfg_ff.dead_zone   <= jdce_pkg::RST_DEAD_ZONE;
         cfg_ff.change_step <= jdce_pkg::RST_CHANGE_STEP;
         cfg_ff.fast_level  <= jdce_pkg::RST_FAST_LEVEL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[design/jdce_ctrl.sv]
// Sequencing state machine: per-axis setup, divide and store, then evaluate and emit.
module jdce_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  jdce_pkg::sts_type sts,
   output jdce_pkg::cmd_type cmd
);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_SETUP    = 7'b0000010,
      ST_DIV      = 7'b0000100,
      ST_STORE    = 7'b0001000,
      ST_EVAL     = 7'b0010000,
      ST_EMIT_JOY = 7'b0100000,
      ST_EMIT_KEY = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      axis_ff, axis_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      axis_in       = axis_ff;
      cmd           = '0;
      cmd.axis_y    = axis_ff;
      cmd.load_item = req_valid & req_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               axis_in  = 1'b0;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (sts.skip_div) begin
               state_in = ST_STORE;
            end else begin
               cmd.div_step = 1'b1;
               if (sts.div_last) state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            if (axis_ff) begin
               state_in = ST_EVAL;
            end else begin
               axis_in  = 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_EMIT_JOY;
         end
         ST_EMIT_JOY: begin
            if (!sts.has_joy) begin
               state_in = sts.has_key ? ST_EMIT_KEY : ST_IDLE;
            end else if (sts.out_free) begin
               cmd.load_joy = 1'b1;
               state_in     = sts.has_key ? ST_EMIT_KEY : ST_IDLE;
            end
         end
         ST_EMIT_KEY: begin
            if (sts.out_free) begin
               cmd.load_key = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
   end

endmodule

[design/jdce_dp.sv]
// Datapath: sample capture, shared restoring divider, decision logic, last-sent state, output.
module jdce_dp (
   input  logic              clock,
   input  logic              reset,
   input  jdce_pkg::req_type req_data,
   input  jdce_pkg::cfg_type cfg,
   input  jdce_pkg::cmd_type cmd,
   output jdce_pkg::sts_type sts,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output jdce_pkg::rsp_type rsp_data
);

   localparam int CFG_W  = jdce_pkg::CFG_W;
   localparam int CMP_W  = jdce_pkg::CMP_W;
   localparam int NUM_W  = jdce_pkg::NUM_W;
   localparam int Q_W    = jdce_pkg::Q_W;
   localparam int CNT_W  = jdce_pkg::CNT_W;
   localparam int NORM_W = jdce_pkg::NORM_W;
   localparam int DIFF_W = jdce_pkg::DIFF_W;
   localparam int SQ_W   = jdce_pkg::SQ_W;

   jdce_pkg::req_type         item_ff, item_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [NUM_W-1:0]          rem_ff, rem_in;
   logic [CFG_W-1:0]          dvs_ff, dvs_in;
   logic [Q_W-1:0]            quo_ff, quo_in;
   logic                      lower_ff, lower_in;
   logic                      skip_ff, skip_in;
   logic signed [NORM_W-1:0]  nx_ff, nx_in, ny_ff, ny_in;
   logic [3:0]                sent_dir_ff, sent_dir_in;
   logic [1:0]                sent_spd_ff, sent_spd_in;
   logic signed [NORM_W-1:0]  sent_x_ff, sent_x_in, sent_y_ff, sent_y_in;
   logic [3:0]                joy_dir_ff, joy_dir_in;
   logic [1:0]                joy_spd_ff, joy_spd_in;
   logic [3:0]                key_ff, key_in;
   logic                      has_joy_ff, has_joy_in, has_key_ff, has_key_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   jdce_pkg::rsp_type         rsp_ff, rsp_in;

   // setup operands
   logic [CFG_W-1:0]  ctr, full, raw_lo, raw_hi;
   logic [CMP_W-1:0]  raw_c, ctr_c, full_c;
   logic [NUM_W-1:0]  num_lo, num_hi, trial;
   logic [NORM_W-1:0] norm_val;

   // evaluation
   logic [NORM_W-1:0]        ax, ay, mag;
   logic [SQ_W-1:0]          sq, fast_lim;
   logic signed [DIFF_W-1:0] th, nxw, nyw, dx, dy;
   logic [DIFF_W-1:0]        adx, ady;
   logic                     x_pos, x_neg, y_pos, y_neg, fast, changed, moved, btn_ok;
   logic [3:0]               dir;
   logic [1:0]               spd;

   always_comb begin
      ctr    = cmd.axis_y ? cfg.center_y : cfg.center_x;
      full   = cmd.axis_y ? cfg.full_y : cfg.full_x;
      raw_c  = CMP_W'(cmd.axis_y ? item_ff.adc_y : item_ff.adc_x);
      ctr_c  = CMP_W'(ctr);
      full_c = CMP_W'(full);
      // below center the sample is under a 12-bit value, so it fits
      raw_lo = raw_c[CFG_W-1:0];
      raw_hi = (raw_c > full_c) ? full : raw_c[CFG_W-1:0];
      num_lo = NUM_W'(raw_lo) * NUM_W'(jdce_pkg::SCALE);
      num_hi = NUM_W'(raw_hi - ctr) * NUM_W'(jdce_pkg::SCALE);
      trial  = NUM_W'(dvs_ff) << cnt_ff;
      norm_val = lower_ff ? (NORM_W'(quo_ff) - NORM_W'(jdce_pkg::SCALE)) : NORM_W'(quo_ff);
   end

   always_comb begin
      ax  = nx_ff[NORM_W-1] ? NORM_W'(-nx_ff) : NORM_W'(nx_ff);
      ay  = ny_ff[NORM_W-1] ? NORM_W'(-ny_ff) : NORM_W'(ny_ff);
      mag = (ax > ay) ? ax : ay;
      sq  = SQ_W'(mag) * SQ_W'(mag);
      // floor(sq/100) > level  <=>  sq >= (level+1)*100
      fast_lim = (SQ_W'(cfg.fast_level) + SQ_W'(1)) * SQ_W'(jdce_pkg::SCALE);
      fast     = (sq >= fast_lim);

      th    = $signed(DIFF_W'(cfg.dead_zone));
      nxw   = DIFF_W'(nx_ff);
      nyw   = DIFF_W'(ny_ff);
      x_pos = (nxw >= th);
      x_neg = (nxw <= -th);
      y_pos = (nyw >= th);
      y_neg = (nyw <= -th);

      spd = fast ? jdce_pkg::SPD_FAST : jdce_pkg::SPD_SLOW;
      if ((ax < NORM_W'(cfg.dead_zone)) && (ay < NORM_W'(cfg.dead_zone))) begin
         dir = jdce_pkg::DIR_STOP;
         spd = jdce_pkg::SPD_STOP;
      end else if (y_pos && x_pos) dir = jdce_pkg::DIR_FR;
      else if (y_neg && x_pos)     dir = jdce_pkg::DIR_BR;
      else if (y_pos && x_neg)     dir = jdce_pkg::DIR_FL;
      else if (y_neg && x_neg)     dir = jdce_pkg::DIR_BL;
      else if (y_pos)              dir = jdce_pkg::DIR_F;
      else if (y_neg)              dir = jdce_pkg::DIR_B;
      else if (x_pos)              dir = jdce_pkg::DIR_R;
      else                         dir = jdce_pkg::DIR_L;

      dx  = nxw - DIFF_W'(sent_x_ff);
      dy  = nyw - DIFF_W'(sent_y_ff);
      adx = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
      ady = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
      moved   = (adx >= DIFF_W'(cfg.change_step)) || (ady >= DIFF_W'(cfg.change_step));
      changed = (dir != sent_dir_ff) || (spd != sent_spd_ff);
      btn_ok  = (item_ff.button >= jdce_pkg::BTN_FIRST) &&
                (item_ff.button <= jdce_pkg::BTN_LAST);
   end

   always_comb begin
      item_in     = item_ff;
      cnt_in      = cnt_ff;
      rem_in      = rem_ff;
      dvs_in      = dvs_ff;
      quo_in      = quo_ff;
      lower_in    = lower_ff;
      skip_in     = skip_ff;
      nx_in       = nx_ff;
      ny_in       = ny_ff;
      sent_dir_in = sent_dir_ff;
      sent_spd_in = sent_spd_ff;
      sent_x_in   = sent_x_ff;
      sent_y_in   = sent_y_ff;
      joy_dir_in  = joy_dir_ff;
      joy_spd_in  = joy_spd_ff;
      key_in      = key_ff;
      has_joy_in  = has_joy_ff;
      has_key_in  = has_key_ff;
      rsp_in      = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;

      if (cmd.load_item) item_in = req_data;

      if (cmd.setup) begin
         cnt_in   = CNT_W'(Q_W - 1);
         quo_in   = '0;
         lower_in = 1'b0;
         skip_in  = 1'b0;
         if (raw_c < ctr_c) begin
            lower_in = 1'b1;
            rem_in   = num_lo;
            dvs_in   = ctr;
         end else if (full == ctr) begin
            skip_in = 1'b1;
         end else if (full < ctr) begin
            // sample clamps to full: ratio is exactly one
            skip_in = 1'b1;
            quo_in  = Q_W'(jdce_pkg::SCALE);
         end else begin
            rem_in = num_hi;
            dvs_in = full - ctr;
         end
      end

      if (cmd.div_step) begin
         if (rem_ff >= trial) begin
            rem_in         = rem_ff - trial;
            quo_in[cnt_ff] = 1'b1;
         end
         cnt_in = cnt_ff - CNT_W'(1);
      end

      if (cmd.store) begin
         if (cmd.axis_y) ny_in = $signed(norm_val);
         else            nx_in = $signed(norm_val);
      end

      if (cmd.eval) begin
         has_joy_in = changed | moved;
         has_key_in = btn_ok;
         joy_dir_in = dir;
         joy_spd_in = spd;
         key_in     = item_ff.button - 4'd1;
         if (btn_ok) begin
            sent_dir_in = jdce_pkg::DIR_STOP;
            sent_spd_in = jdce_pkg::SPD_STOP;
            sent_x_in   = '0;
            sent_y_in   = '0;
         end else if (changed | moved) begin
            sent_dir_in = dir;
            sent_spd_in = spd;
            sent_x_in   = nx_ff;
            sent_y_in   = ny_ff;
         end
      end

      if (cmd.load_joy) begin
         rsp_in.msg_kind    = ((joy_dir_ff == jdce_pkg::DIR_STOP) &&
                               (joy_spd_ff == jdce_pkg::SPD_STOP)) ?
                              jdce_pkg::MSG_STOP : jdce_pkg::MSG_MOVE;
         rsp_in.direction   = joy_dir_ff;
         rsp_in.speed       = joy_spd_ff;
         rsp_in.key_code    = '0;
         rsp_in.last_of_run = ~has_key_ff;
         rsp_valid_in       = 1'b1;
      end else if (cmd.load_key) begin
         rsp_in.msg_kind    = jdce_pkg::MSG_KEY;
         rsp_in.direction   = jdce_pkg::DIR_STOP;
         rsp_in.speed       = jdce_pkg::SPD_STOP;
         rsp_in.key_code    = key_ff;
         rsp_in.last_of_run = 1'b1;
         rsp_valid_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_dir_ff  <= jdce_pkg::DIR_NONE;
         sent_spd_ff  <= jdce_pkg::SPD_NONE;
         sent_x_ff    <= '0;
         sent_y_ff    <= '0;
         has_joy_ff   <= 1'b0;
         has_key_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sent_dir_ff  <= sent_dir_in;
         sent_spd_ff  <= sent_spd_in;
         sent_x_ff    <= sent_x_in;
         sent_y_ff    <= sent_y_in;
         has_joy_ff   <= has_joy_in;
         has_key_ff   <= has_key_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      cnt_ff     <= cnt_in;
      rem_ff     <= rem_in;
      dvs_ff     <= dvs_in;
      quo_ff     <= quo_in;
      lower_ff   <= lower_in;
      skip_ff    <= skip_in;
      nx_ff      <= nx_in;
      ny_ff      <= ny_in;
      joy_dir_ff <= joy_dir_in;
      joy_spd_ff <= joy_spd_in;
      key_ff     <= key_in;
      rsp_ff     <= rsp_in;
   end

   assign sts.skip_div = skip_ff;
   assign sts.div_last = (cnt_ff == '0);
   assign sts.has_joy  = has_joy_ff;
   assign sts.has_key  = has_key_ff;
   assign sts.out_free = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // output register is only loaded when its transaction has gone or is going
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_joy || cmd.load_key) |-> (!rsp_valid_ff || rsp_ready))
      else $error("output loaded while occupied");

   // a finished division leaves a remainder below the divisor
   a_rem_small: assert property (@(posedge clock) disable iff (reset)
      (cmd.store && !skip_ff) |-> (rem_ff < NUM_W'(dvs_ff)))
      else $error("divider remainder out of range");

   // normalized axes stay within full scale
   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      cmd.eval |-> ((nx_ff >= -NORM_W'(jdce_pkg::SCALE)) && (nx_ff <= NORM_W'(jdce_pkg::SCALE)) &&
                    (ny_ff >= -NORM_W'(jdce_pkg::SCALE)) && (ny_ff <= NORM_W'(jdce_pkg::SCALE))))
      else $error("normalized axis out of range");

endmodule

[design/joystick_direction_command_encoder.sv]
// Top level of the joystick direction command encoder.
// Each req transaction carries one x/y sample pair and a button code. The block
// maps each axis around its configured center to -100..100, picks stop or one
// of eight directions with slow/fast speed, and sends a stop or direction
// message on rsp when the command changed or an axis moved by change_step
// since the last message, followed by a key message when a button is pressed
// (last_of_run marks the final message of an input). After an acceptance
// req_ready stays low until the input has been fully handled, including any
// stall on rsp. The two axes share one restoring divider that resolves one
// quotient bit per cycle; the division is skipped when the sample is at or
// above center and full is at or below center. Each axis also passes a setup
// state and a store state. Then come a decision state, a stop/direction
// message state (entered even when nothing is sent) and a key message state
// when a key message follows; both message states wait while rsp is occupied.
// The last message is held in an output register, so the next input can be
// taken while it waits. Configuration registers sit at byte address 4*i; the
// user must write them only while the block is idle; the block does not enforce it.
module joystick_direction_command_encoder (
   input  logic                         clock,
   input  logic                         reset,
   // input transactions
   input  logic                         req_valid,
   output logic                         req_ready,
   input  jdce_pkg::req_type            req_data,
   // result transactions
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output jdce_pkg::rsp_type            rsp_data,
   // configuration
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [jdce_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [jdce_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [jdce_pkg::DATA_W-1:0]  csr_prdata,
   output logic                         csr_pready
);

   jdce_pkg::cfg_type cfg;
   jdce_pkg::cmd_type cmd;
   jdce_pkg::sts_type sts;

   // register file
   jdce_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencer: accepts a transaction only when idle
   jdce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // divider, decision logic, last-sent state and output register
   jdce_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cfg       (cfg),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
